// ===== sv/obrf_pkg.sv =====
// Shared types and constants for the overlapped block ring framer.
// No dependencies; every file but obrf_ram imports this package.
package obrf_pkg;

    // Sample store geometry: depth is a power of two, addresses are a mask
    localparam int STORE_AW    = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    // Field widths
    localparam int WORD_W  = 32;
    localparam int POS_W   = 48;
    localparam int SIZE_W  = 17;
    localparam int OVL_W   = 16;

    // Command queue between front and back
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Configuration port
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_CAPTURE_SIZE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BLOCK_SIZE   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_OVERLAP      = 2'd2;

    localparam logic [SIZE_W-1:0] CAPTURE_SIZE_RST = 17'd32000;
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST   = 17'd48000;
    localparam logic [OVL_W-1:0]  OVERLAP_RST      = 16'd1000;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } t_kind;

    // Input word
    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  sample_in;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [WORD_W-1:0]  sample_out;
        logic               last_in_block;
        logic               ready_res;
    } t_out_word;

    // Read status carried alongside a store read
    typedef struct packed {
        logic ok;     // block data fully written
        logic pad;    // offset beyond capture, word is zero
        logic last;   // final word of the block
    } t_rd_flags;

    // Classified command handed from front to back
    typedef struct packed {
        t_kind               kind;
        t_rd_flags           flags;
        logic [STORE_AW-1:0] addr;
        logic [WORD_W-1:0]   data;
    } t_cmd;

endpackage

// ===== sv/obrf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module obrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds until the next read enable
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/obrf_queue.sv =====
// Small command FIFO between the framer front and back.
// Depends on obrf_pkg.
module obrf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  obrf_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output obrf_pkg::t_cmd o_head
);
    import obrf_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/obrf_front.sv =====
// Framer front: holds configuration and stream counters, accepts words,
// classifies each as a store write or a block read and queues a command.
// Depends on obrf_pkg.
module obrf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  obrf_pkg::t_in_word            i_in_word,
    input  logic                          i_cfg_wr_en,
    input  logic [obrf_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [obrf_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output obrf_pkg::t_cmd                o_push_cmd
);
    import obrf_pkg::*;

    logic [SIZE_W-1:0]   r_capture;
    logic [SIZE_W-1:0]   r_block_size;
    logic [OVL_W-1:0]    r_overlap;
    logic [POS_W-1:0]    r_wr_total;
    logic [POS_W-1:0]    r_blk_start;
    logic [SIZE_W-1:0]   r_off;

    logic [SIZE_W-1:0]   len;
    logic [POS_W:0]      need;
    logic                ok;
    logic [SIZE_W:0]     off_inc;
    logic                last;
    logic                pad;
    logic [SIZE_W-1:0]   step;
    logic [STORE_AW-1:0] rd_addr;
    logic                accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    // Read classification against the current block
    always_comb begin
        len     = (r_block_size == '0) ? SIZE_W'(1) : r_block_size;
        need    = {1'b0, r_blk_start} + (POS_W + 1)'(r_capture);
        ok      = ({1'b0, r_wr_total} >= need);
        off_inc = {1'b0, r_off} + (SIZE_W + 1)'(1);
        last    = (off_inc >= {1'b0, len});
        pad     = (r_off >= r_capture);
        step    = (r_capture > SIZE_W'(r_overlap)) ? r_capture - SIZE_W'(r_overlap) : '0;
        rd_addr = r_blk_start[STORE_AW-1:0] + STORE_AW'(r_off);
    end

    // Command for the back
    always_comb begin
        o_push_cmd.kind       = i_in_word.kind;
        o_push_cmd.data       = i_in_word.sample_in;
        o_push_cmd.flags.ok   = ok;
        o_push_cmd.flags.pad  = pad;
        o_push_cmd.flags.last = last;
        unique case (i_in_word.kind)
            KIND_WRITE: o_push_cmd.addr = r_wr_total[STORE_AW-1:0];
            KIND_READ:  o_push_cmd.addr = rd_addr;
            default:    o_push_cmd.addr = rd_addr;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture    <= CAPTURE_SIZE_RST;
            r_block_size <= BLOCK_SIZE_RST;
            r_overlap    <= OVERLAP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_CAPTURE_SIZE: r_capture    <= i_cfg_data;
                CFG_BLOCK_SIZE:   r_block_size <= i_cfg_data;
                CFG_OVERLAP:      r_overlap    <= i_cfg_data[OVL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Stream position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_total  <= '0;
            r_blk_start <= '0;
            r_off       <= '0;
        end else if (accept) begin
            if (i_in_word.kind == KIND_WRITE) begin
                r_wr_total <= r_wr_total + POS_W'(1);
            end else if (ok) begin
                if (last) begin
                    r_blk_start <= r_blk_start + POS_W'(step);
                    r_off       <= '0;
                end else begin
                    r_off <= off_inc[SIZE_W-1:0];
                end
            end
        end
    end

endmodule

// ===== sv/obrf_back.sv =====
// Framer back: executes queued commands against the sample store and
// formats block words into a registered output stage.
// Depends on obrf_pkg and obrf_ram.
module obrf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  obrf_pkg::t_cmd      i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output obrf_pkg::t_out_word o_out_word
);
    import obrf_pkg::*;

    logic              r_s1_valid;
    t_rd_flags         r_s1_flags;
    logic              r_out_valid;
    t_out_word         r_out_word;
    logic [WORD_W-1:0] rdata;
    logic              s1_adv;
    logic              head_rd;
    logic              out_load;

    assign head_rd  = (i_head.kind == KIND_READ);
    assign out_load = !r_out_valid || i_out_ready;
    assign s1_adv   = !r_s1_valid || out_load;
    // Writes never wait; a read waits for room in the read stage
    assign o_pop    = !i_q_empty && (!head_rd || s1_adv);

    obrf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (o_pop && !head_rd),
        .i_waddr (i_head.addr),
        .i_wdata (i_head.data),
        .i_re    (o_pop && head_rd),
        .i_raddr (i_head.addr),
        .o_rdata (rdata)
    );

    // Read stage: flags travel with the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= o_pop && head_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_flags <= i_head.flags;
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_word.sample_out    <= (r_s1_flags.ok && !r_s1_flags.pad) ? rdata : '0;
            r_out_word.last_in_block <= r_s1_flags.ok && r_s1_flags.last;
            r_out_word.ready_res     <= r_s1_flags.ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== sv/overlapped_block_ring_framer.sv =====
// Overlapped block ring framer, top level. Ties front, command queue and back.
// Depends on obrf_pkg, obrf_front, obrf_queue, obrf_back.
//
// Write words (kind 0) go into a 65536-entry sample store; read words (kind 1)
// each return one word of the current block: capture_size samples from the
// store, zero padding up to block_size, last_in_block on the final word, and
// a not-ready answer (all zero) while the block is not fully written.
// Successive blocks start capture_size - overlap samples apart. The block takes
// one word per cycle while the queue has room: the front classifies and updates
// its counters in the accept cycle, a four-entry command queue decouples it
// from the back, and the back does one store access per cycle unless a read
// waits for read-stage room. A read result passes the queue, the read stage
// and the output register. The store has no clearing pass after reset.
// Configuration writes take effect at once and belong to idle periods only.
module overlapped_block_ring_framer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  obrf_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output obrf_pkg::t_out_word         o_out_word,
    input  logic                        i_cfg_wr_en,
    input  logic [obrf_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [obrf_pkg::SIZE_W-1:0] i_cfg_data
);
    import obrf_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head;

    obrf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_cmd  (push_cmd)
    );

    obrf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_empty    (q_empty),
        .o_head     (head)
    );

    obrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for overlapped_block_ring_framer: directed and random
// word streams, checked against a behavioral model of the block kept here.
// Depends on obrf_pkg and the overlapped_block_ring_framer RTL.
module tb_top;
    import obrf_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    // Clock, reset and block ports
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_word         in_word = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_word        out_word;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0] cfg_idx = '0;
    logic [SIZE_W-1:0] cfg_data = '0;

    // Pending stimulus and expected results
    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    logic      in_taken = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // Model of the framer: sample store, stream counters, current block
    logic [WORD_W-1:0] sample_mem [0:STORE_DEPTH-1];
    logic [POS_W-1:0]  fill_count = '0;
    logic [POS_W-1:0]  frame_base = '0;
    logic [SIZE_W-1:0] frame_pos = '0;
    logic [SIZE_W-1:0] cap_len = CAPTURE_SIZE_RST;
    logic [SIZE_W-1:0] frame_len = BLOCK_SIZE_RST;
    logic [OVL_W-1:0]  overlap_len = OVERLAP_RST;

    // Run statistics
    int unsigned mismatch_count = 0;
    int unsigned writes_sent = 0;
    int unsigned reads_sent = 0;
    int unsigned results_checked = 0;
    int unsigned ready_seen = 0;
    int unsigned ends_seen = 0;
    int unsigned setting_changes = 0;

    overlapped_block_ring_framer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Timeout guard
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("ERROR @%0t: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Advance the model by one accepted input word
    task automatic frame_step(input t_in_word w);
        t_out_word         res;
        logic [POS_W:0]    need;
        logic [SIZE_W-1:0] eff_len;
        logic [SIZE_W:0]   next_pos;
        logic [POS_W-1:0]  rd_pos;
        if (w.kind == KIND_WRITE) begin
            sample_mem[fill_count[STORE_AW-1:0]] = w.sample_in;
            fill_count = fill_count + 1'b1;
        end else begin
            res = '0;
            need = {1'b0, frame_base} + (POS_W + 1)'(cap_len);
            // not ready: all-zero answer, nothing advances
            if ({1'b0, fill_count} >= need) begin
                eff_len = frame_len;
                if (frame_len == '0)
                    eff_len = SIZE_W'(1);
                rd_pos = frame_base + frame_pos;
                if (frame_pos < cap_len)
                    res.sample_out = sample_mem[rd_pos[STORE_AW-1:0]];
                res.ready_res = 1'b1;
                next_pos = frame_pos + 1'b1;
                if (next_pos >= {1'b0, eff_len}) begin
                    res.last_in_block = 1'b1;
                    // step saturates at zero when overlap reaches capture size
                    if (cap_len > {1'b0, overlap_len})
                        frame_base = frame_base + (cap_len - overlap_len);
                    frame_pos = '0;
                end else begin
                    frame_pos = next_pos[SIZE_W-1:0];
                end
            end
            expected_words.push_back(res);
        end
    endtask

    // Driver: new word or idle at the falling edge, receiver stalls at random
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && (!in_valid || in_taken)) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_word  <= pending_words.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: feed accepted input words to the model, check output words
    always @(posedge clk) begin
        t_out_word want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            frame_step(in_word);
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected output word", out_word.sample_out, '0);
            end else begin
                want = expected_words.pop_front();
                results_checked++;
                if (want.ready_res)
                    ready_seen++;
                if (want.last_in_block)
                    ends_seen++;
                if (out_word.sample_out !== want.sample_out)
                    report_mismatch("sample_out", out_word.sample_out, want.sample_out);
                if (out_word.last_in_block !== want.last_in_block)
                    report_mismatch("last_in_block", out_word.last_in_block,
                                    want.last_in_block);
                if (out_word.ready_res !== want.ready_res)
                    report_mismatch("ready_res", out_word.ready_res, want.ready_res);
            end
        end
    end

    task automatic push_write(input logic [WORD_W-1:0] v);
        t_in_word w;
        w.kind = KIND_WRITE;
        w.sample_in = v;
        pending_words.push_back(w);
        writes_sent++;
    endtask

    task automatic push_reads(input int n);
        t_in_word w;
        for (int i = 0; i < n; i++) begin
            w.kind = KIND_READ;
            w.sample_in = $urandom;
            pending_words.push_back(w);
            reads_sent++;
        end
    endtask

    function automatic logic [WORD_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Block until no input is pending and no result is outstanding
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_poke(input logic [CFG_IW-1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_CAPTURE_SIZE: cap_len = val;
            CFG_BLOCK_SIZE:   frame_len = val;
            CFG_OVERLAP:      overlap_len = val[OVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int cap, input int blk, input int ovl);
        cfg_poke(CFG_CAPTURE_SIZE, SIZE_W'(cap));
        cfg_poke(CFG_BLOCK_SIZE, SIZE_W'(blk));
        cfg_poke(CFG_OVERLAP, SIZE_W'(ovl));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        setting_changes++;
    endtask

    // Random traffic: mostly write bursts that fill blocks followed by read
    // bursts that drain them, with some mixed noise in between
    task automatic queue_traffic(input int n);
        int left;
        int burst;
        int step;
        t_in_word w;
        left = n;
        step = (cap_len > overlap_len) ? cap_len - overlap_len : 1;
        while (left > 0) begin
            case ($urandom_range(9))
                0, 1: begin
                    burst = $urandom_range(1, 6);
                    for (int i = 0; i < burst; i++) begin
                        w.kind = t_kind'($urandom_range(1));
                        w.sample_in = rand_sample();
                        pending_words.push_back(w);
                        if (w.kind == KIND_WRITE)
                            writes_sent++;
                        else
                            reads_sent++;
                    end
                end
                default: begin
                    burst = $urandom_range(0, cap_len + step);
                    for (int i = 0; i < burst; i++)
                        push_write(rand_sample());
                    left -= burst;
                    burst = $urandom_range(1, 2 * frame_len + 2);
                    push_reads(burst);
                end
            endcase
            left -= burst;
        end
    endtask

    // Stimulus sequence
    initial begin
        int rcap;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first idling mix: sender sparse, receiver sparser
        send_idle_pct = 33;
        recv_idle_pct = 55;

        // reset settings: nothing written, so the block is not ready
        push_reads(1);
        wait_idle();

        // one full block with padding, then the next block before and after it is written
        apply_settings(4, 6, 1);
        push_reads(1);
        push_write(32'h0000_0000);
        push_write(32'hFFFF_FFFF);
        push_write(32'hA5A5_A5A5);
        push_write(32'h5A5A_5A5A);
        push_reads(6);
        push_reads(1);
        push_write(32'h0000_0001);
        push_write(32'h8000_0000);
        push_write($urandom);
        push_reads(2);
        wait_idle();

        // zero block size, overlap above capture: the same block repeats,
        // and the held offset is already past the new block end
        apply_settings(2, 0, 65535);
        push_reads(3);
        wait_idle();

        // 65536-word block, then block size lowered below the current offset
        apply_settings(3, 65536, 0);
        push_reads(3);
        wait_idle();
        apply_settings(3, 2, 0);
        push_reads(2);
        wait_idle();

        // unused register index, then a 65536-sample capture size
        cfg_poke(CFG_UNUSED, 17'h1FFFF);
        apply_settings(65536, 65536, 65535);
        push_reads(1);
        wait_idle();

        apply_settings(8, 12, 3);
        queue_traffic(300);
        wait_idle();
        apply_settings(5, 5, 0);
        queue_traffic(280);
        wait_idle();

        // second idling mix: roles swapped
        send_idle_pct = 55;
        recv_idle_pct = 33;
        apply_settings(16, 10, 4);
        queue_traffic(280);
        wait_idle();
        apply_settings(6, 9, 6);
        queue_traffic(200);
        wait_idle();
        apply_settings(1, 1, 0);
        queue_traffic(150);
        wait_idle();

        // no idling: a short write burst, then a full-store capture that
        // is still short of data
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(4, 4, 0);
        for (int i = 0; i < 40; i++)
            push_write($urandom);
        push_reads(8);
        wait_idle();
        apply_settings(65536, 3, 0);
        push_reads(3);
        wait_idle();

        apply_settings(3, 4, 2);
        queue_traffic(250);
        wait_idle();
        repeat (2) begin
            rcap = $urandom_range(1, 20);
            apply_settings(rcap, $urandom_range(0, 24), $urandom_range(0, rcap + 1));
            queue_traffic(130);
            wait_idle();
        end

        $display("Sent %0d write words and %0d read words across %0d settings.",
                 writes_sent, reads_sent, setting_changes);
        $display("Checked %0d result words: %0d ready, %0d block ends.",
                 results_checked, ready_seen, ends_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
